/* rtl/bmpw_pkg.sv */
// Shared types, constants and header byte table for the BMP stream writer.
package bmpw_pkg;

    // Dimension and counter widths
    localparam int DIM_W     = 13;
    localparam int CNT_W     = 12;
    localparam int IDX_W     = 6;
    localparam int ROWB_W    = 15;
    localparam int FSIZE_W   = 32;
    localparam int PIX_W     = 24;
    localparam int BYTE_W    = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Register reset values and the file geometry that follows from them
    localparam int RST_WIDTH    = 640;
    localparam int RST_HEIGHT   = 640;
    localparam int RST_PAD      = (4 - ((3 * RST_WIDTH) % 4)) % 4;
    localparam int RST_ROWBYTES = 3 * RST_WIDTH + RST_PAD;
    localparam int HDR_BYTES    = 54;
    localparam int RST_FSIZE    = HDR_BYTES + RST_HEIGHT * RST_ROWBYTES;

    // Byte positions within one item's sequence
    localparam logic [IDX_W-1:0] IDX_BLUE  = IDX_W'(HDR_BYTES);
    localparam logic [IDX_W-1:0] IDX_GREEN = IDX_W'(HDR_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_RED   = IDX_W'(HDR_BYTES + 2);

    // Fixed header field values
    localparam logic [7:0] MAGIC_B    = 8'h42;
    localparam logic [7:0] MAGIC_M    = 8'h4D;
    localparam logic [7:0] INFO_SIZE  = 8'd40;
    localparam logic [7:0] PLANES     = 8'd1;
    localparam logic [7:0] BITS_PIXEL = 8'd24;

    // Effective image geometry handed from the register block to the sequencer
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [1:0]         pad;
        logic [FSIZE_W-1:0] fsize;
    } dims_t;

    // Header byte at a given offset, little endian multi-byte fields
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                                   input dims_t dims);
        logic [BYTE_W-1:0] b;
        b = '0;
        case (idx)
            6'd0:    b = MAGIC_B;
            6'd1:    b = MAGIC_M;
            6'd2:    b = dims.fsize[7:0];
            6'd3:    b = dims.fsize[15:8];
            6'd4:    b = dims.fsize[23:16];
            6'd5:    b = dims.fsize[31:24];
            6'd10:   b = BYTE_W'(HDR_BYTES);
            6'd14:   b = INFO_SIZE;
            6'd18:   b = dims.width[7:0];
            6'd19:   b = {3'b000, dims.width[12:8]};
            6'd22:   b = dims.height[7:0];
            6'd23:   b = {3'b000, dims.height[12:8]};
            6'd26:   b = PLANES;
            6'd28:   b = BITS_PIXEL;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

/* rtl/bmpw_cfg.sv */
// Configuration registers, dimension clamping and file size computation.
module bmpw_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpw_pkg::APB_AW-1:0]   paddr,
    input  logic [bmpw_pkg::APB_DW-1:0]   pwdata,
    output logic [bmpw_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output bmpw_pkg::dims_t               dims
);
    import bmpw_pkg::*;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [ROWB_W-1:0]  row_bytes_reg;
    logic [FSIZE_W-1:0] fsize_reg;
    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;
    logic [1:0]         pad;
    logic [1:0]         triple_lo;
    logic [ROWB_W-1:0]  row_bytes_next;
    logic [FSIZE_W-1:0] fsize_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write registers on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(RST_WIDTH);
            height_reg <= DIM_W'(RST_HEIGHT);
        end else if (wr_en) begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Saturate to 1..MAX
    always_comb begin
        if (width_reg == '0)
            width_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            width_eff = DIM_W'(MAX_WIDTH);
        else
            width_eff = width_reg;
        if (height_reg == '0)
            height_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            height_eff = DIM_W'(MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    // Row padding: bring 3*width up to a multiple of four
    assign triple_lo      = width_eff[1:0] + {width_eff[0], 1'b0};
    assign pad            = 2'b00 - triple_lo;
    assign row_bytes_next = ROWB_W'(width_eff) + ROWB_W'({width_eff, 1'b0})
                            + ROWB_W'(pad);
    assign fsize_next     = FSIZE_W'(HDR_BYTES)
                            + FSIZE_W'(height_eff * row_bytes_reg);

    // Pipeline the size: row bytes, then one multiply and add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg <= ROWB_W'(RST_ROWBYTES);
            fsize_reg     <= FSIZE_W'(RST_FSIZE);
        end else begin
            row_bytes_reg <= row_bytes_next;
            fsize_reg     <= fsize_next;
        end
    end

    assign dims.width  = width_eff;
    assign dims.height = height_eff;
    assign dims.pad    = pad;
    assign dims.fsize  = fsize_reg;

endmodule

/* rtl/bmpw_seq.sv */
// Pixel register, row/column counters and byte sequencer with output register.
module bmpw_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bmpw_pkg::dims_t               dims,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmpw_pkg::PIX_W-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bmpw_pkg::BYTE_W-1:0]   m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    import bmpw_pkg::*;

    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  row_reg;
    logic              item_valid_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  last_idx_reg;
    logic              eoi_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_eoi_reg;

    logic              item_last;
    logic              load;
    logic              accept;
    logic              row_end;
    logic              img_end;
    logic              first_pix;
    logic [BYTE_W-1:0] byte_next;

    // Handshake
    assign item_last = (idx_reg == last_idx_reg);
    assign load      = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !item_valid_reg || (load && item_last);
    assign accept    = s_tvalid && s_tready;

    // Row and image boundaries for the incoming pixel
    assign row_end   = ({1'b0, col_reg} + DIM_W'(1)) >= dims.width;
    assign img_end   = row_end && (({1'b0, row_reg} + DIM_W'(1)) >= dims.height);
    assign first_pix = (col_reg == '0) && (row_reg == '0);

    // Pick the byte at the current position
    always_comb begin
        if (idx_reg < IDX_BLUE)
            byte_next = hdr_byte(idx_reg, dims);
        else if (idx_reg == IDX_BLUE)
            byte_next = pix_reg[7:0];
        else if (idx_reg == IDX_GREEN)
            byte_next = pix_reg[15:8];
        else if (idx_reg == IDX_RED)
            byte_next = pix_reg[23:16];
        else
            byte_next = '0;
    end

    // Advance counters on each accepted pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= img_end ? '0 : row_reg + CNT_W'(1);
            end else begin
                col_reg <= col_reg + CNT_W'(1);
            end
        end
    end

    // Hold the pixel being serialized
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (accept) begin
            item_valid_reg <= 1'b1;
        end else if (load && item_last) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg      <= s_tdata;
            idx_reg      <= first_pix ? '0 : IDX_BLUE;
            last_idx_reg <= IDX_RED + (row_end ? IDX_W'(dims.pad) : '0);
            eoi_reg      <= img_end;
        end else if (load) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= byte_next;
            out_last_reg <= item_last;
            out_eoi_reg  <= item_last && eoi_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_eoi_reg;

endmodule

/* rtl/bmp24_stream_writer.sv */
// Top level of the 24-bit BMP byte stream writer.
//
//  port group   dir   payload
//  s_t*         in    tdata[23:0] = blue, green, red (one pixel)
//  m_t*         out   tdata[7:0] = file byte, tlast = last byte of pixel,
//                     tuser[0] = last byte of file
//  p*           cfg   0x0 image_width, 0x4 image_height
//
// Each pixel yields 3 bytes at one byte per cycle from the output register
// while m_tready is high, plus 54 header bytes for the first pixel of a file
// and 0..3 pad bytes at the end of each row, so 3, up to 6, or up to 60 in all.
// The next pixel is taken in the cycle its predecessor's last byte enters
// the output register. Reset clears counters so the next pixel opens a file.
// Stalls on m_tready hold the output byte and back up into s_tready.
module bmp24_stream_writer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmpw_pkg::PIX_W-1:0]    s_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bmpw_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser,   // [0] end_of_image
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpw_pkg::APB_AW-1:0]   paddr,
    input  logic [bmpw_pkg::APB_DW-1:0]   pwdata,
    output logic [bmpw_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bmpw_pkg::*;

    dims_t dims;

    // Registers and file geometry
    bmpw_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    // Byte sequencer
    bmpw_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dims     (dims),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser[0])
    );

endmodule

/* rtl/bmpw_checker.sv */
// Port-level checks for the BMP stream writer, bound to the top level.
module bmpw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bmpw_pkg::BYTE_W-1:0]   m_tdata,
    input logic                          m_tlast,
    input logic [0:0]                    m_tuser
);
    import bmpw_pkg::*;

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
        && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled output transaction changed");

    // File end always closes a pixel's run
    a_eoi_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("end of image without end of run");

    // Come out of reset empty and ready
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> s_tready && !m_tvalid)
        else $error("not idle after reset");

    // A valid output transaction carries known byte and flags
    a_out_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast, m_tuser}))
        else $error("unknown value on a valid output transaction");

endmodule

bind bmp24_stream_writer bmpw_checker u_bmpw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
